/* rtl/bbo_pkg.sv */
// Shared types and constants for the occupancy cell update block.
`default_nettype none
package bbo_pkg;

    typedef struct packed {
        logic        func;
        logic [15:0] cell_index;
        logic [1:0]  observation;
    } item_t;

    typedef struct packed {
        logic [15:0] false_positive_prob;
        logic [15:0] false_negative_prob;
        logic [15:0] prior_prob;
        logic [15:0] conf_ceiling;
    } cfg_t;

    typedef enum logic [1:0] {
        MODE_KEEP  = 2'd0,
        MODE_HIT   = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_e;

    typedef enum logic [2:0] {
        REG_FALSE_POS = 3'd0,
        REG_FALSE_NEG = 3'd1,
        REG_PRIOR     = 3'd2,
        REG_MAX_CONF  = 3'd3,
        REG_ENABLE    = 3'd4
    } cfg_reg_e;

    localparam logic       FUNC_LOAD = 1'b0;
    localparam logic [1:0] OBS_CLEAR = 2'd1;
    localparam logic [1:0] OBS_HIT   = 2'd2;

    localparam int FQ_DEPTH = 4;
    localparam int FQ_AW    = 2;

endpackage
`default_nettype wire

/* rtl/binary_bayes_occupancy_cell_update_top.sv */
// Top level of the occupancy cell update block: config registers and the two halves.
//
// Input channel (push/full): one request names a cell; func 0 loads the prior,
// func 1 applies the observation (1 clear, 2 hit, else none) as a Bayes update.
// Result channel (empty/pop): cell_number and its new cost byte, in request order.
// Requests for cells outside the grid, or while the layer is disabled, give none.
// Config channel (cfg_valid/cfg_ready): cfg_ready is always high; write only
// while no request is in flight.
// Throughput: one request per cycle for distinct cells while the result queue has
// room. A request to a cell that is still in the update pipeline waits until its
// write-back, which follows the restoring divider (one quotient bit a stage).
// A request passes the input queue, the cell read, stages 1 to 3, the divider and the result queue.
// When the receiver stalls, the result queue fills; issue stops once every slot
// is claimed by queued or in-flight results, then the input queue fills and
// full rises. Reset clears all queues and restores config defaults; cell
// contents are undefined until loaded.
`default_nettype none
module binary_bayes_occupancy_cell_update_top #(
    parameter int GRID_CELLS = 65536,
    parameter int PROB_BITS  = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        func,
    input  wire logic [15:0] cell_index,
    input  wire logic [1:0]  observation,
    output logic             empty,
    input  wire logic        pop,
    output logic [15:0]      cell_number,
    output logic [7:0]       cost,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import bbo_pkg::*;

    cfg_t  cfg_reg;
    logic  enabled_reg;
    item_t item_in;
    item_t q_item;
    logic  q_valid;
    logic  q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.false_positive_prob <= 16'd6554;
            cfg_reg.false_negative_prob <= 16'd6554;
            cfg_reg.prior_prob          <= 16'd32768;
            cfg_reg.conf_ceiling        <= 16'd62259;
            enabled_reg                 <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FALSE_POS: cfg_reg.false_positive_prob <= cfg_data;
                REG_FALSE_NEG: cfg_reg.false_negative_prob <= cfg_data;
                REG_PRIOR:     cfg_reg.prior_prob          <= cfg_data;
                REG_MAX_CONF:  cfg_reg.conf_ceiling        <= cfg_data;
                REG_ENABLE:    enabled_reg                 <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    assign item_in.func        = func;
    assign item_in.cell_index  = cell_index;
    assign item_in.observation = observation;

    bbo_front #(
        .GRID_CELLS(GRID_CELLS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .enabled (enabled_reg),
        .push    (push),
        .full    (full),
        .item_in (item_in),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    bbo_back #(
        .GRID_CELLS(GRID_CELLS),
        .PROB_BITS (PROB_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .cell_number (cell_number),
        .cost        (cost)
    );

endmodule
`default_nettype wire

/* rtl/bbo_front.sv */
// Front end: accepts requests, drops those that produce nothing, queues the rest.
`default_nettype none
module bbo_front #(
    parameter int GRID_CELLS = 65536
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           enabled,
    input  wire logic           push,
    output logic                full,
    input  wire bbo_pkg::item_t item_in,
    output logic                q_valid,
    output bbo_pkg::item_t      q_item,
    input  wire logic           q_pop
);
    import bbo_pkg::*;

    item_t            fq_mem [FQ_DEPTH];
    logic [FQ_AW-1:0] wr_ptr_reg;
    logic [FQ_AW-1:0] rd_ptr_reg;
    logic [FQ_AW:0]   cnt_reg;
    logic             keep;
    logic             wr_en;
    logic             rd_en;

    assign full    = (cnt_reg == (FQ_AW+1)'(FQ_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = fq_mem[rd_ptr_reg];

    // out-of-grid cells and a disabled layer give no result at all
    assign keep  = enabled && (32'(item_in.cell_index) < 32'(GRID_CELLS));
    assign wr_en = push && !full && keep;
    assign rd_en = q_pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fq_mem[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (!wr_en && rd_en)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/bbo_back.sv */
// Back end: cell store, Bayes update pipeline with pipelined divider, result queue.
`default_nettype none
module bbo_back #(
    parameter int GRID_CELLS = 65536,
    parameter int PROB_BITS  = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire bbo_pkg::cfg_t  cfg,
    input  wire logic           q_valid,
    input  wire bbo_pkg::item_t q_item,
    output logic                q_pop,
    output logic                empty,
    input  wire logic           pop,
    output logic [15:0]         cell_number,
    output logic [7:0]          cost
);
    import bbo_pkg::*;

    localparam int P        = PROB_BITS;
    localparam int NW       = 2*P + 2;
    localparam int AW       = $clog2(GRID_CELLS);
    localparam int ND       = P + 1;
    localparam int OQ_AW    = $clog2(P + 6);
    localparam int OQ_DEPTH = 2**OQ_AW;
    localparam logic [P:0] ONE = {1'b1, {P{1'b0}}};

    function automatic logic [P-1:0] to_q(input logic [15:0] v);
        logic [P+15:0] w;
        w = {v, {P{1'b0}}} >> 16;
        return w[P-1:0];
    endfunction

    // cell store
    logic [P-1:0]  cell_mem [GRID_CELLS];
    logic [P-1:0]  rd_reg;

    // issue
    logic          hazard;
    logic          issue;
    logic [31:0]   idx_ext;
    logic [AW-1:0] issue_addr;
    logic [OQ_AW:0] reserved_reg;
    logic          out_pop;

    // stage 1
    logic          s1_valid_reg;
    item_t         s1_item_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [P-1:0]  s1_base;
    mode_e         s1_mode;
    logic [P:0]    a_po;
    logic [P:0]    a_pe;
    logic [P:0]    b_pe;
    logic [2*P:0]  po_next;
    logic [2*P+1:0] pe_next;

    // stage 2
    logic           s2_valid_reg;
    logic [15:0]    s2_idx_reg;
    logic [AW-1:0]  s2_addr_reg;
    mode_e          s2_mode_reg;
    logic [P-1:0]   s2_base_reg;
    logic [2*P:0]   s2_po_reg;
    logic [2*P+1:0] s2_pe_reg;

    // stage 3
    logic          s3_valid_reg;
    logic [15:0]   s3_idx_reg;
    logic [AW-1:0] s3_addr_reg;
    mode_e         s3_mode_reg;
    logic [P-1:0]  s3_base_reg;
    logic [NW-1:0] s3_num_reg;
    logic [NW-1:0] s3_den_reg;

    // divider stages
    logic          d_valid_reg [ND];
    logic [15:0]   d_idx_reg   [ND];
    logic [AW-1:0] d_addr_reg  [ND];
    mode_e         d_mode_reg  [ND];
    logic [P-1:0]  d_base_reg  [ND];
    logic          d_zden_reg  [ND];
    logic [NW-1:0] d_den_reg   [ND];
    logic [NW-1:0] d_rem_reg   [ND];
    logic [P:0]    d_q_reg     [ND];
    logic [NW-1:0] d_rem_next  [ND];
    logic [P:0]    d_q_next    [ND];

    // final
    logic          wr_en;
    logic [P-1:0]  new_p;
    logic [P:0]    mx;
    logic [P:0]    lo;
    logic [P:0]    clamped;
    logic [P:0]    q_fin;

    // result queue
    logic [15:0]    oq_idx  [OQ_DEPTH];
    logic [7:0]     oq_cost [OQ_DEPTH];
    logic [OQ_AW-1:0] oq_wr_reg;
    logic [OQ_AW-1:0] oq_rd_reg;
    logic [OQ_AW:0]   oq_cnt_reg;

    // ---------------- issue ----------------
    always_comb
    begin
        hazard = (s1_valid_reg && s1_item_reg.cell_index == q_item.cell_index)
              || (s2_valid_reg && s2_idx_reg == q_item.cell_index)
              || (s3_valid_reg && s3_idx_reg == q_item.cell_index);
        for (int k = 0; k < ND; k++)
        begin
            if (d_valid_reg[k] && d_idx_reg[k] == q_item.cell_index)
            begin
                hazard = 1'b1;
            end
        end
    end

    assign idx_ext    = 32'(q_item.cell_index);
    assign issue_addr = idx_ext[AW-1:0];
    // credit check keeps room in the result queue for everything in flight
    assign issue      = q_valid && !hazard && (reserved_reg < (OQ_AW+1)'(OQ_DEPTH));
    assign q_pop      = issue;
    assign out_pop    = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_reg <= cell_mem[issue_addr];
        end
        if (wr_en)
        begin
            cell_mem[d_addr_reg[ND-1]] <= new_p;
        end
    end

    // ---------------- stage 1: products ----------------
    always_comb
    begin
        if (s1_item_reg.func == FUNC_LOAD)
        begin
            s1_base = to_q(cfg.prior_prob);
            s1_mode = MODE_KEEP;
        end
        else
        begin
            s1_base = rd_reg;
            if (s1_item_reg.observation == OBS_HIT)
            begin
                s1_mode = MODE_HIT;
            end
            else if (s1_item_reg.observation == OBS_CLEAR)
            begin
                s1_mode = MODE_CLEAR;
            end
            else
            begin
                s1_mode = MODE_KEEP;
            end
        end
        b_pe = ONE - {1'b0, rd_reg};
        if (s1_mode == MODE_HIT)
        begin
            a_po = ONE - {1'b0, to_q(cfg.false_negative_prob)};
            a_pe = {1'b0, to_q(cfg.false_positive_prob)};
        end
        else
        begin
            a_po = {1'b0, to_q(cfg.false_negative_prob)};
            a_pe = ONE - {1'b0, to_q(cfg.false_positive_prob)};
        end
        po_next = (2*P+1)'(a_po) * (2*P+1)'(rd_reg);
        pe_next = (2*P+2)'(a_pe) * (2*P+2)'(b_pe);
    end

    // ---------------- divider steps ----------------
    always_comb
    begin
        logic [NW:0] r2;
        r2 = '0;
        if (s3_num_reg >= s3_den_reg)
        begin
            d_rem_next[0] = s3_num_reg - s3_den_reg;
            d_q_next[0]   = (P+1)'(1);
        end
        else
        begin
            d_rem_next[0] = s3_num_reg;
            d_q_next[0]   = '0;
        end
        for (int k = 1; k < ND; k++)
        begin
            r2 = {d_rem_reg[k-1], 1'b0};
            if (r2 >= {1'b0, d_den_reg[k-1]})
            begin
                r2 = r2 - {1'b0, d_den_reg[k-1]};
                d_q_next[k] = {d_q_reg[k-1][P-1:0], 1'b1};
            end
            else
            begin
                d_q_next[k] = {d_q_reg[k-1][P-1:0], 1'b0};
            end
            d_rem_next[k] = r2[NW-1:0];
        end
    end

    // ---------------- final: clamp, write back ----------------
    always_comb
    begin
        mx    = {1'b0, to_q(cfg.conf_ceiling)};
        lo    = ONE - mx;
        q_fin = d_q_reg[ND-1];
        if (d_mode_reg[ND-1] == MODE_HIT)
        begin
            clamped = (q_fin < mx) ? q_fin : mx;
        end
        else
        begin
            clamped = (q_fin > lo) ? q_fin : lo;
        end
        if (clamped >= ONE)
        begin
            clamped = ONE - 1'b1;
        end
        if (d_mode_reg[ND-1] == MODE_KEEP || d_zden_reg[ND-1])
        begin
            new_p = d_base_reg[ND-1];
        end
        else
        begin
            new_p = clamped[P-1:0];
        end
    end

    assign wr_en = d_valid_reg[ND-1];

    // ---------------- pipeline payload ----------------
    always_ff @(posedge clk)
    begin
        s1_item_reg <= q_item;
        s1_addr_reg <= issue_addr;

        s2_idx_reg  <= s1_item_reg.cell_index;
        s2_addr_reg <= s1_addr_reg;
        s2_mode_reg <= s1_mode;
        s2_base_reg <= s1_base;
        s2_po_reg   <= po_next;
        s2_pe_reg   <= pe_next;

        s3_idx_reg  <= s2_idx_reg;
        s3_addr_reg <= s2_addr_reg;
        s3_mode_reg <= s2_mode_reg;
        s3_base_reg <= s2_base_reg;
        s3_num_reg  <= NW'(s2_po_reg);
        s3_den_reg  <= NW'(s2_po_reg) + NW'(s2_pe_reg);

        d_idx_reg[0]  <= s3_idx_reg;
        d_addr_reg[0] <= s3_addr_reg;
        d_mode_reg[0] <= s3_mode_reg;
        d_base_reg[0] <= s3_base_reg;
        d_zden_reg[0] <= (s3_den_reg == '0);
        d_den_reg[0]  <= s3_den_reg;
        for (int k = 1; k < ND; k++)
        begin
            d_idx_reg[k]  <= d_idx_reg[k-1];
            d_addr_reg[k] <= d_addr_reg[k-1];
            d_mode_reg[k] <= d_mode_reg[k-1];
            d_base_reg[k] <= d_base_reg[k-1];
            d_zden_reg[k] <= d_zden_reg[k-1];
            d_den_reg[k]  <= d_den_reg[k-1];
        end
        for (int k = 0; k < ND; k++)
        begin
            d_rem_reg[k] <= d_rem_next[k];
            d_q_reg[k]   <= d_q_next[k];
        end

        if (wr_en)
        begin
            oq_idx[oq_wr_reg]  <= d_idx_reg[ND-1];
            oq_cost[oq_wr_reg] <= new_p[P-1 -: 8];
        end
    end

    // ---------------- control ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            for (int k = 0; k < ND; k++)
            begin
                d_valid_reg[k] <= 1'b0;
            end
            reserved_reg <= '0;
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_cnt_reg   <= '0;
        end
        else
        begin
            s1_valid_reg   <= issue;
            s2_valid_reg   <= s1_valid_reg;
            s3_valid_reg   <= s2_valid_reg;
            d_valid_reg[0] <= s3_valid_reg;
            for (int k = 1; k < ND; k++)
            begin
                d_valid_reg[k] <= d_valid_reg[k-1];
            end
            if (issue && !out_pop)
            begin
                reserved_reg <= reserved_reg + 1'b1;
            end
            else if (!issue && out_pop)
            begin
                reserved_reg <= reserved_reg - 1'b1;
            end
            if (wr_en)
            begin
                oq_wr_reg <= oq_wr_reg + 1'b1;
            end
            if (out_pop)
            begin
                oq_rd_reg <= oq_rd_reg + 1'b1;
            end
            if (wr_en && !out_pop)
            begin
                oq_cnt_reg <= oq_cnt_reg + 1'b1;
            end
            else if (!wr_en && out_pop)
            begin
                oq_cnt_reg <= oq_cnt_reg - 1'b1;
            end
        end
    end

    assign empty       = (oq_cnt_reg == '0);
    assign cell_number = oq_idx[oq_rd_reg];
    assign cost        = oq_cost[oq_rd_reg];

endmodule
`default_nettype wire

/* bench/tb_binary_bayes_occupancy_cell_update_top.sv */
// Self-checking testbench for the occupancy cell update block.
`timescale 1ns / 100ps
module tb_binary_bayes_occupancy_cell_update_top;
    import bbo_pkg::*;

    localparam logic       FUNC_OBSERVE = 1'b1;
    localparam logic [1:0] OBS_NONE     = 2'd0;
    localparam logic [1:0] OBS_RSVD     = 2'd3;
    localparam longint unsigned ONE_Q   = 64'd65536;
    localparam int SETTLE_CYCLES        = 40;
    localparam int WATCHDOG_LIMIT       = 3000;
    localparam int HOLD_CYCLES          = 300;

    typedef struct {
        logic [15:0] cell_number;
        logic [7:0]  cost;
    } cost_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        func = 1'b0;
    logic [15:0] cell_index = '0;
    logic [1:0]  observation = '0;
    logic        pop = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        full, empty, cfg_ready;
    logic [15:0] cell_number;
    logic [7:0]  cost;

    binary_bayes_occupancy_cell_update_top dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .func(func),
        .cell_index(cell_index), .observation(observation), .empty(empty), .pop(pop),
        .cell_number(cell_number), .cost(cost), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    item_t       pending_items[$];
    cost_t       expected_costs[$];
    logic [15:0] cell_prob[0:65535];
    cfg_t        cur_cfg = '{16'd6554, 16'd6554, 16'd32768, 16'd62259};
    logic        cur_enable = 1'b1;
    int          errors = 0;
    int          n_results = 0;
    bit          quiet = 0;
    int          stall_cycles = 0;

    // generator-side view of which cells hold a value
    bit          gen_loaded[0:65535];
    bit          gen_enable = 1;
    logic [15:0] hot_cells[8];

    // Bayes update of one cell; returns 1 when a result is produced
    function automatic bit update_cell(input item_t it, output cost_t res);
        longint unsigned p, fp, fn, mx, po, pe, q, lo;
        if (!cur_enable)
            return 0;
        fp = cur_cfg.false_positive_prob;
        fn = cur_cfg.false_negative_prob;
        mx = cur_cfg.conf_ceiling;
        if (it.func == FUNC_LOAD) begin
            p = cur_cfg.prior_prob;
        end
        else begin
            p = cell_prob[it.cell_index];
            if (it.observation == OBS_HIT) begin
                po = (ONE_Q - fn) * p;
                pe = fp * (ONE_Q - p);
                if (po + pe != 0) begin
                    q = (po << 16) / (po + pe);
                    p = (q < mx) ? q : mx;
                end
            end
            else if (it.observation == OBS_CLEAR) begin
                lo = ONE_Q - mx;
                po = fn * p;
                pe = (ONE_Q - fp) * (ONE_Q - p);
                if (po + pe != 0) begin
                    q = (po << 16) / (po + pe);
                    p = (q > lo) ? q : lo;
                end
            end
        end
        if (p >= ONE_Q)
            p = ONE_Q - 1;
        cell_prob[it.cell_index] = p[15:0];
        res.cell_number = it.cell_index;
        res.cost = p[15:8];
        return 1;
    endfunction

    // request acceptance, prediction and config tracking
    always @(posedge clk)
    begin
        item_t it;
        cost_t res;
        if (push && !full) begin
            it = pending_items.pop_front();
            if (update_cell(it, res))
                expected_costs.push_back(res);
        end
        if (cfg_valid && cfg_ready) begin
            case (cfg_reg_e'(cfg_index))
                REG_FALSE_POS: cur_cfg.false_positive_prob <= cfg_data;
                REG_FALSE_NEG: cur_cfg.false_negative_prob <= cfg_data;
                REG_PRIOR:     cur_cfg.prior_prob <= cfg_data;
                REG_MAX_CONF:  cur_cfg.conf_ceiling <= cfg_data;
                REG_ENABLE:    cur_enable <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // request driver
    int  push_gap = 0;
    bit  just_taken = 0;
    always @(posedge clk)
        just_taken <= push && !full;

    always @(negedge clk)
    begin
        if (just_taken && !quiet && $urandom_range(0, 3) == 0)
            push_gap = $urandom_range(1, 3);
        if (push_gap > 0) begin
            push_gap--;
            push <= 1'b0;
        end
        else if (pending_items.size() > 0) begin
            push <= 1'b1;
            func <= pending_items[0].func;
            cell_index <= pending_items[0].cell_index;
            observation <= pending_items[0].observation;
        end
        else
            push <= 1'b0;
    end

    // result monitor
    always @(posedge clk)
    begin
        cost_t want;
        if (pop && !empty) begin
            n_results <= n_results + 1;
            if (expected_costs.size() == 0) begin
                $error("unexpected result cell_number=%0d cost=%0d", cell_number, cost);
                errors++;
            end
            else begin
                want = expected_costs.pop_front();
                if (cell_number !== want.cell_number) begin
                    $error("cell_number: expected %0d, got %0d", want.cell_number, cell_number);
                    errors++;
                end
                if (cost !== want.cost) begin
                    $error("cost: expected %0d, got %0d", want.cost, cost);
                    errors++;
                end
            end
        end
    end

    int pop_gap = 0;
    bit held = 0;
    always @(negedge clk)
    begin
        // one long receiver stall so the block backs up into full
        if (!held && n_results >= 60) begin
            held = 1;
            stall_cycles = HOLD_CYCLES;
        end
        if (stall_cycles > 0) begin
            stall_cycles--;
            pop <= 1'b0;
        end
        else if (pop_gap > 0) begin
            pop_gap--;
            pop <= 1'b0;
        end
        else begin
            if (!quiet && $urandom_range(0, 4) == 0) begin
                pop_gap = $urandom_range(0, 2);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // watchdog on cycles with no request of any kind accepted
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(input cfg_reg_e idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_ENABLE)
            gen_enable = data[0];
    endtask

    task automatic wait_drained();
        wait (pending_items.size() == 0 && expected_costs.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_item(input logic f, input logic [15:0] idx, input logic [1:0] obs);
        item_t it;
        it.func = f;
        it.cell_index = idx;
        it.observation = obs;
        if (f == FUNC_LOAD && gen_enable)
            gen_loaded[idx] = 1;
        pending_items.push_back(it);
    endtask

    task automatic add_random(input int n);
        logic [15:0] idx;
        logic [1:0]  obs;
        for (int i = 0; i < n; i++) begin
            idx = ($urandom_range(0, 1) == 0) ? hot_cells[$urandom_range(0, 7)]
                                              : 16'($urandom);
            if (!gen_loaded[idx] || $urandom_range(0, 7) == 0)
                add_item(FUNC_LOAD, idx, 2'($urandom));
            else begin
                case ($urandom_range(0, 9))
                    0:       obs = OBS_NONE;
                    1:       obs = OBS_RSVD;
                    2, 3, 4: obs = OBS_CLEAR;
                    default: obs = OBS_HIT;
                endcase
                add_item(FUNC_OBSERVE, idx, obs);
            end
        end
    endtask

    task automatic set_all(input logic [15:0] fp, input logic [15:0] fn,
                           input logic [15:0] prior, input logic [15:0] mx);
        write_reg(REG_FALSE_POS, fp);
        write_reg(REG_FALSE_NEG, fn);
        write_reg(REG_PRIOR, prior);
        write_reg(REG_MAX_CONF, mx);
    endtask

    initial
    begin
        foreach (hot_cells[i])
            hot_cells[i] = 16'($urandom);
        hot_cells[0] = 16'h0000;
        hot_cells[1] = 16'hFFFF;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes of cells, every observation, clamps at both ends
        add_item(FUNC_LOAD, 16'h0000, OBS_NONE);
        add_item(FUNC_LOAD, 16'hFFFF, OBS_RSVD);
        add_item(FUNC_OBSERVE, 16'hFFFF, OBS_NONE);
        add_item(FUNC_OBSERVE, 16'hFFFF, OBS_RSVD);
        repeat (6) add_item(FUNC_OBSERVE, 16'h0000, OBS_HIT);
        repeat (6) add_item(FUNC_OBSERVE, 16'hFFFF, OBS_CLEAR);
        add_item(FUNC_OBSERVE, 16'h0000, OBS_CLEAR);
        add_item(FUNC_OBSERVE, 16'hFFFF, OBS_HIT);
        add_item(FUNC_OBSERVE, 16'h5A5A, OBS_HIT);
        add_item(FUNC_LOAD, 16'h5A5A, OBS_HIT);
        add_item(FUNC_OBSERVE, 16'h5A5A, OBS_HIT);
        wait_drained();

        add_random(110);
        wait_drained();

        // disabled layer: nothing changes, nothing comes out
        write_reg(REG_ENABLE, 16'd0);
        add_random(20);
        wait_drained();
        write_reg(REG_ENABLE, 16'd1);

        set_all(16'd1, 16'd1, 16'd1, 16'd32768);
        add_random(100);
        wait_drained();

        set_all(16'd65535, 16'd65535, 16'd65535, 16'd65535);
        add_random(100);
        wait_drained();

        set_all(16'd1, 16'd65535, 16'd65535, 16'd65535);
        add_random(80);
        wait_drained();

        set_all(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                16'($urandom_range(1, 65535)), 16'($urandom_range(32768, 65535)));
        add_random(80);
        wait_drained();

        quiet = 1;
        set_all(16'd6554, 16'd6554, 16'd32768, 16'd62259);
        add_random(120);
        wait_drained();

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
